@@ src/sss_pkg.sv @@
package sss_pkg;

  localparam int TIME_W     = 14;
  localparam int ANGLE_W    = 8;
  localparam int NOW_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [TIME_W-1:0]  TIME_MAX_MS    = 14'd10000;
  localparam logic [TIME_W-1:0]  TIME_RESET_MS  = 14'd1000;
  localparam logic [ANGLE_W-1:0] ANGLE_MIN_DEG  = 8'd10;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX_DEG  = 8'd180;
  localparam logic [ANGLE_W-1:0] ANGLE_RESET    = 8'd120;
  localparam logic [ANGLE_W-1:0] CENTER_DEG     = 8'd90;
  // 1000 / 120 with the reset configuration
  localparam logic [TIME_W-1:0]  DELAY_RESET    = 14'd8;

  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_TIME    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_ANGLE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELAY_PRESENT = 2'd2;

  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_PLACE = 1'b1;

  typedef struct packed {
    logic             operation;
    logic             toward_max;
    logic [NOW_W-1:0] now_ms;
  } sss_in_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] position_deg;
    logic               position_changed;
    logic               at_end;
    logic               relay_write;
    logic               relay_level;
  } sss_out_t;

endpackage

@@ src/servo_sweep_stepper_core.sv @@
// servo sweep stepper: moves a commanded servo angle one degree per step item
// toward the minimum or maximum end (90 -/+ half the sweep angle).
// input channel in_valid/in_ready/in_data carries a place or step item with a
// millisecond timestamp; every item gives exactly one result on
// out_valid/out_ready/out_data.
// the result is registered; one item per cycle is sustained while the receiver
// keeps out_ready high and no step delay divide is running.
// a skid register holds one extra result, so the block still takes an item in
// the cycle the receiver first stalls; in_ready drops once both are full.
// configuration: cfg_valid/cfg_ready/cfg_index/cfg_data; a write of the sweep
// time or sweep angle starts a shift-subtract divide for the step
// delay, during which in_ready and cfg_ready stay low.
// reset (rst, synchronous): angle 90, motion disabled, last move time 0,
// registers 1000 ms / 120 deg / no relay, step delay 8, both result
// registers empty.
module servo_sweep_stepper_core
  import sss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sss_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sss_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DIV_STEPS = TIME_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // configuration and state
  logic [TIME_W-1:0]  sweep_time;
  logic [ANGLE_W-1:0] sweep_angle;
  logic               relay_present;
  logic [TIME_W-1:0]  step_delay;
  logic [ANGLE_W-1:0] angle;
  logic [NOW_W-1:0]   last_move_time;
  logic               motion_enabled;

  // divider
  logic               div_busy;
  logic [CNT_W-1:0]   div_count;
  logic [TIME_W-1:0]  div_quot;
  logic [ANGLE_W-1:0] div_rem;
  logic [ANGLE_W:0]   div_trial;
  logic               div_fit;
  logic [ANGLE_W:0]   div_sub;

  // result registers
  sss_out_t out_reg;
  logic     out_valid_q;
  logic     skid_valid;
  sss_out_t skid_reg;

  logic               in_xfer;
  logic               cfg_xfer;
  logic [TIME_W-1:0]  cfg_time;
  logic [ANGLE_W-1:0] cfg_angle_raw;
  logic [ANGLE_W-1:0] cfg_angle;

  logic [ANGLE_W-1:0] half_span;
  logic [ANGLE_W-1:0] end_low;
  logic [ANGLE_W-1:0] end_high;
  logic               away;
  logic [NOW_W-1:0]   elapsed;
  logic               move;
  logic [ANGLE_W-1:0] angle_next;
  sss_out_t           res;

  assign in_ready  = !div_busy && !skid_valid;
  assign cfg_ready = !div_busy;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign out_valid = out_valid_q;
  assign out_data  = out_reg;

  // register write saturation
  assign cfg_time      = (cfg_data > CFG_DATA_W'(TIME_MAX_MS)) ? TIME_MAX_MS
                                                                : TIME_W'(cfg_data);
  assign cfg_angle_raw = cfg_data[ANGLE_W-1:0];
  assign cfg_angle     = (cfg_angle_raw > ANGLE_MAX_DEG) ? ANGLE_MAX_DEG :
                         (cfg_angle_raw < ANGLE_MIN_DEG) ? ANGLE_MIN_DEG : cfg_angle_raw;

  // one quotient bit per cycle
  assign div_trial = {div_rem, div_quot[TIME_W-1]};
  assign div_fit   = div_trial >= {1'b0, sweep_angle};
  assign div_sub   = div_trial - {1'b0, sweep_angle};

  // item datapath
  assign half_span = {1'b0, sweep_angle[ANGLE_W-1:1]};
  assign end_low   = CENTER_DEG - half_span;
  assign end_high  = CENTER_DEG + half_span;
  assign away      = in_data.toward_max ? (angle < end_high) : (angle > end_low);
  assign elapsed   = in_data.now_ms - last_move_time;
  assign move      = (in_data.operation == OP_STEP) && away && motion_enabled
                     && (elapsed > NOW_W'(step_delay));

  always_comb begin
    angle_next = angle;
    res        = '0;
    if (in_data.operation == OP_PLACE) begin
      angle_next           = in_data.toward_max ? end_high : end_low;
      res.position_changed = 1'b1;
    end else if (away) begin
      if (move) begin
        angle_next           = in_data.toward_max ? angle + 8'd1 : angle - 8'd1;
        res.position_changed = 1'b1;
      end
    end else begin
      res.at_end = 1'b1;
      if (relay_present) begin
        res.relay_write = 1'b1;
        res.relay_level = !in_data.toward_max;
      end
    end
    res.position_deg = angle_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_time     <= TIME_RESET_MS;
      sweep_angle    <= ANGLE_RESET;
      relay_present  <= 1'b0;
      step_delay     <= DELAY_RESET;
      div_busy       <= 1'b0;
      div_count      <= '0;
      angle          <= CENTER_DEG;
      last_move_time <= '0;
      motion_enabled <= 1'b0;
      out_valid_q    <= 1'b0;
      skid_valid     <= 1'b0;
    end else begin
      if (cfg_xfer) begin
        case (cfg_index)
          REG_SWEEP_TIME: begin
            sweep_time <= cfg_time;
            div_quot   <= cfg_time;
            div_rem    <= '0;
            div_count  <= CNT_W'(DIV_STEPS - 1);
            div_busy   <= 1'b1;
          end
          REG_SWEEP_ANGLE: begin
            sweep_angle <= cfg_angle;
            div_quot    <= sweep_time;
            div_rem     <= '0;
            div_count   <= CNT_W'(DIV_STEPS - 1);
            div_busy    <= 1'b1;
          end
          REG_RELAY_PRESENT: relay_present <= cfg_data[0];
          default: ;
        endcase
      end else if (div_busy) begin
        div_rem  <= div_fit ? div_sub[ANGLE_W-1:0] : div_trial[ANGLE_W-1:0];
        div_quot <= {div_quot[TIME_W-2:0], div_fit};
        if (div_count == '0) begin
          div_busy   <= 1'b0;
          step_delay <= {div_quot[TIME_W-2:0], div_fit};
        end else begin
          div_count <= div_count - CNT_W'(1);
        end
      end

      if (in_xfer) begin
        angle <= angle_next;
        if (in_data.operation == OP_PLACE) begin
          motion_enabled <= 1'b1;
        end
        if (move) begin
          last_move_time <= in_data.now_ms;
        end
      end

      // output register with one skid entry behind it
      if (!out_valid_q || out_ready) begin
        if (skid_valid) begin
          out_reg     <= skid_reg;
          out_valid_q <= 1'b1;
          skid_valid  <= 1'b0;
        end else if (in_xfer) begin
          out_reg     <= res;
          out_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b0;
        end
      end else if (in_xfer) begin
        skid_reg   <= res;
        skid_valid <= 1'b1;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid_q)
    else $error("skid entry held without an output entry");

  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (!in_ready && !cfg_ready))
    else $error("transfer possible while step delay is being computed");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    angle <= ANGLE_MAX_DEG)
    else $error("commanded angle out of range");

  a_div_start: assert property (@(posedge clk) disable iff (rst)
    (cfg_xfer && (cfg_index == REG_SWEEP_TIME || cfg_index == REG_SWEEP_ANGLE))
    |=> div_busy)
    else $error("divider not started after sweep register write");

endmodule
